### src/tec_pkg.sv
`timescale 1ns / 1ps

package tec_pkg;

  typedef enum logic [2:0] {
    ENC_UTF8    = 3'd0,
    ENC_ANSI    = 3'd1,
    ENC_U16LE   = 3'd2,
    ENC_U16BE   = 3'd3,
    ENC_U32FFFE = 3'd4,
    ENC_U32FEFF = 3'd5,
    ENC_NONE    = 3'd6
  } enc_t;

  typedef struct packed {
    enc_t encoding;
    logic damaged;
  } tec_result_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] count;
  } lead_t;

  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_FE     = 8'hFE;
  localparam logic [7:0] BYTE_FF     = 8'hFF;
  localparam logic [2:0] HEAD_BYTES  = 3'd4;
  localparam logic [2:0] MAX_PENDING = 3'd5;

  // Number of continuation bytes a lead byte opens under the loose UTF-8 rule.
  function automatic lead_t lead_continuations(input logic [7:0] b);
    lead_t r;
    r.ok    = 1'b1;
    r.count = 3'd0;
    if (b[7] == 1'b0) begin
      r.count = 3'd0;
    end else if (b[7:5] == 3'b110) begin
      r.count = 3'd1;
    end else if (b[7:4] == 4'b1110) begin
      r.count = 3'd2;
    end else if (b[7:3] == 5'b11110) begin
      r.count = 3'd3;
    end else if (b[7:2] == 6'b111110) begin
      r.count = 3'd4;
    end else if (b[7:1] == 7'b1111110) begin
      r.count = 3'd5;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

### src/tec_in_if.sv
`timescale 1ns / 1ps

interface tec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink (input valid, input data_byte, input last, output ready);
endinterface

### src/tec_out_if.sv
`timescale 1ns / 1ps

interface tec_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] encoding;
  logic       damaged;

  modport source (output valid, output encoding, output damaged, input ready);
  modport sink (input valid, input encoding, input damaged, output ready);
endinterface

### src/tec_rules.sv
`timescale 1ns / 1ps

module tec_rules import tec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output tec_result_t result
);

  logic [2:0]  utf8_pending, utf8_pending_next;
  logic        utf8_failed, utf8_failed_next;
  logic        ansi_pending, ansi_pending_next;
  logic        ansi_failed, ansi_failed_next;
  logic [2:0]  byte_position, byte_position_next;
  logic [1:0]  length_mod_four, length_mod_four_next;
  logic [31:0] head_bytes, head_bytes_next;
  lead_t       lead;
  logic        high;
  logic        even_len;
  logic        quad_len;

  assign lead = lead_continuations(data_byte);
  assign high = data_byte[7];

  always_comb begin
    utf8_pending_next    = utf8_pending;
    utf8_failed_next     = utf8_failed;
    ansi_pending_next    = ansi_pending;
    ansi_failed_next     = ansi_failed;
    byte_position_next   = byte_position;
    head_bytes_next      = head_bytes;
    length_mod_four_next = length_mod_four + 2'd1;

    if (!utf8_failed) begin
      if (utf8_pending != 3'd0) begin
        if (data_byte[7:6] == 2'b10) begin
          utf8_pending_next = utf8_pending - 3'd1;
        end else begin
          utf8_failed_next = 1'b1;
        end
      end else if (!lead.ok) begin
        utf8_failed_next = 1'b1;
      end else begin
        utf8_pending_next = lead.count;
      end
    end

    if (!ansi_failed) begin
      if (ansi_pending) begin
        if (high) begin
          ansi_pending_next = 1'b0;
        end else begin
          ansi_failed_next = 1'b1;
        end
      end else if (high) begin
        ansi_pending_next = 1'b1;
      end
    end

    // The first four bytes are kept; later bytes only advance the length.
    if (byte_position < HEAD_BYTES) begin
      for (int i = 0; i < 4; i++) begin
        if (byte_position[1:0] == 2'(i)) begin
          head_bytes_next[8*i +: 8] = head_bytes[8*i +: 8] | data_byte;
        end
      end
      byte_position_next = byte_position + 3'd1;
    end
  end

  assign even_len = (length_mod_four_next[0] == 1'b0);
  assign quad_len = (length_mod_four_next == 2'd0);

  always_comb begin
    result.damaged = 1'b0;
    if (!utf8_failed_next && utf8_pending_next == 3'd0) begin
      result.encoding = ENC_UTF8;
    end else if (!ansi_failed_next && !ansi_pending_next) begin
      result.encoding = ENC_ANSI;
    end else if (byte_position_next >= 3'd2 && even_len &&
                 head_bytes_next[7:0] == BYTE_FF && head_bytes_next[15:8] == BYTE_FE) begin
      result.encoding = ENC_U16LE;
    end else if (byte_position_next >= 3'd2 && even_len &&
                 head_bytes_next[7:0] == BYTE_FE && head_bytes_next[15:8] == BYTE_FF) begin
      result.encoding = ENC_U16BE;
    end else if (byte_position_next >= HEAD_BYTES && quad_len &&
                 head_bytes_next[15:0] == {BYTE_ZERO, BYTE_ZERO} &&
                 head_bytes_next[23:16] == BYTE_FF && head_bytes_next[31:24] == BYTE_FE) begin
      result.encoding = ENC_U32FFFE;
    end else if (byte_position_next >= HEAD_BYTES && quad_len &&
                 head_bytes_next[15:0] == {BYTE_ZERO, BYTE_ZERO} &&
                 head_bytes_next[23:16] == BYTE_FE && head_bytes_next[31:24] == BYTE_FF) begin
      result.encoding = ENC_U32FEFF;
    end else begin
      result.encoding = ENC_NONE;
      result.damaged  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && last)) begin
      utf8_pending    <= 3'd0;
      utf8_failed     <= 1'b0;
      ansi_pending    <= 1'b0;
      ansi_failed     <= 1'b0;
      byte_position   <= 3'd0;
      length_mod_four <= 2'd0;
      head_bytes      <= 32'd0;
    end else if (advance) begin
      utf8_pending    <= utf8_pending_next;
      utf8_failed     <= utf8_failed_next;
      ansi_pending    <= ansi_pending_next;
      ansi_failed     <= ansi_failed_next;
      byte_position   <= byte_position_next;
      length_mod_four <= length_mod_four_next;
      head_bytes      <= head_bytes_next;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    advance && last |=> byte_position == 3'd0 && length_mod_four == 2'd0 &&
                        head_bytes == 32'd0 && !utf8_failed && !ansi_failed)
    else $error("stream state not cleared after final byte");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= HEAD_BYTES)
    else $error("byte position ran past the head");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    utf8_pending <= MAX_PENDING)
    else $error("UTF-8 pending count out of range");

  a_damaged_none: assert property (@(posedge clk) disable iff (rst)
    result.damaged == (result.encoding == ENC_NONE))
    else $error("damaged flag disagrees with encoding");

endmodule

### src/tec_out_reg.sv
`timescale 1ns / 1ps

module tec_out_reg import tec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  tec_result_t result,
  output logic        free,
  tec_out_if.source   verdict
);

  logic        valid;
  tec_result_t held;

  assign free = !valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (verdict.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign verdict.valid    = valid;
  assign verdict.encoding = held.encoding;
  assign verdict.damaged  = held.damaged;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    valid && !verdict.ready |-> !load)
    else $error("pending transaction overwritten");

endmodule

### src/text_encoding_classifier.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                      Meaning
// stream    in   data_byte[7:0], last         one text byte, last marks end of stream
// verdict   out  encoding[2:0], damaged       one transaction per stream, on its last byte
//
// One byte is accepted per cycle, unless a final byte waits on a full output register.
// A byte is captured in the input register and checked against all rules while it is
// held there; on a final byte the result is loaded into the output register once that
// register is free, and the verdict is driven from the output register.
// Synchronous reset clears both registers' valid flags and the rule state.
// While the verdict waits, non-final bytes keep flowing; only a final byte
// waits for the output register to free up.

module text_encoding_classifier import tec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  tec_in_if.sink   stream,
  tec_out_if.source verdict
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;
  logic        out_free;
  tec_result_t result;

  assign advance      = s1_valid && (!s1_last || out_free);
  assign stream.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (stream.ready) begin
      s1_valid <= stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      s1_byte <= stream.data_byte;
      s1_last <= stream.last;
    end
  end

  tec_rules u_rules (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (s1_byte),
    .last      (s1_last),
    .result    (result)
  );

  tec_out_reg u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (advance && s1_last),
    .result  (result),
    .free    (out_free),
    .verdict (verdict)
  );

endmodule

### sim/tb_text_encoding_classifier.sv
`timescale 1ns / 1ps

module tb_text_encoding_classifier;
  import tec_pkg::*;

  localparam int LONG_HOLD = 250;

  logic clk = 1'b0;
  logic rst;

  tec_in_if  stream_if ();
  tec_out_if verdict_if ();

  text_encoding_classifier DUT (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_if),
    .verdict (verdict_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Tracks the rule state of the open stream and holds the verdicts owed by the block.
  class verdict_scoreboard;
    logic [2:0]  u8_owed;
    bit          u8_broken;
    bit          ansi_open;
    bit          ansi_broken;
    logic [2:0]  seen;
    logic [1:0]  len_mod4;
    logic [31:0] head;
    tec_result_t verdicts_due[$];
    int          errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      u8_owed     = 3'd0;
      u8_broken   = 1'b0;
      ansi_open   = 1'b0;
      ansi_broken = 1'b0;
      seen        = 3'd0;
      len_mod4    = 2'd0;
      head        = 32'd0;
    endfunction

    function void note_byte(logic [7:0] b, logic fin);
      tec_result_t r;
      bit          even_len;
      if (!u8_broken) begin
        if (u8_owed != 3'd0) begin
          if (b[7:6] == 2'b10) u8_owed = u8_owed - 3'd1;
          else u8_broken = 1'b1;
        end else begin
          casez (b)
            8'b0???????: u8_owed = 3'd0;
            8'b110?????: u8_owed = 3'd1;
            8'b1110????: u8_owed = 3'd2;
            8'b11110???: u8_owed = 3'd3;
            8'b111110??: u8_owed = 3'd4;
            8'b1111110?: u8_owed = 3'd5;
            default:     u8_broken = 1'b1;
          endcase
        end
      end

      if (!ansi_broken) begin
        if (ansi_open) begin
          if (b[7]) ansi_open = 1'b0;
          else ansi_broken = 1'b1;
        end else if (b[7]) begin
          ansi_open = 1'b1;
        end
      end

      if (seen < 3'd4) begin
        head[8*seen +: 8] = b;
        seen = seen + 3'd1;
      end
      len_mod4 = len_mod4 + 2'd1;

      if (!fin) return;

      even_len  = (len_mod4[0] == 1'b0);
      r.damaged = 1'b0;
      if (!u8_broken && u8_owed == 3'd0) begin
        r.encoding = ENC_UTF8;
      end else if (!ansi_broken && !ansi_open) begin
        r.encoding = ENC_ANSI;
      end else if (seen >= 3'd2 && even_len && head[7:0] == BYTE_FF && head[15:8] == BYTE_FE) begin
        r.encoding = ENC_U16LE;
      end else if (seen >= 3'd2 && even_len && head[7:0] == BYTE_FE && head[15:8] == BYTE_FF) begin
        r.encoding = ENC_U16BE;
      end else if (seen >= 3'd4 && len_mod4 == 2'd0 && head[15:0] == 16'h0000 &&
                   head[23:16] == BYTE_FF && head[31:24] == BYTE_FE) begin
        r.encoding = ENC_U32FFFE;
      end else if (seen >= 3'd4 && len_mod4 == 2'd0 && head[15:0] == 16'h0000 &&
                   head[23:16] == BYTE_FE && head[31:24] == BYTE_FF) begin
        r.encoding = ENC_U32FEFF;
      end else begin
        r.encoding = ENC_NONE;
        r.damaged  = 1'b1;
      end
      verdicts_due.insert(verdicts_due.size(), r);
      clear();
    endfunction

    function void check_verdict(logic [2:0] enc, logic dmg);
      tec_result_t want;
      if (verdicts_due.size() == 0) begin
        $error("verdict with no stream pending: encoding %0d, damaged %0d", enc, dmg);
        errors++;
        return;
      end
      want = verdicts_due.pop_front();
      if (enc !== want.encoding) begin
        $error("encoding: expected %0d, got %0d", want.encoding, enc);
        errors++;
      end
      if (dmg !== want.damaged) begin
        $error("damaged: expected %0d, got %0d", want.damaged, dmg);
        errors++;
      end
    endfunction
  endclass

  verdict_scoreboard sb = new();

  int gap_pct   = 0;
  int stall_pct = 0;
  bit pressure_on = 1'b0;
  logic [7:0] stream_bytes[$];

  always @(posedge clk) begin
    if (!rst && stream_if.valid && stream_if.ready)
      sb.note_byte(stream_if.data_byte, stream_if.last);
    if (!rst && verdict_if.valid && verdict_if.ready)
      sb.check_verdict(verdict_if.encoding, verdict_if.damaged);
  end

  // Receiver side; the long hold-off is counted here once pressure is requested.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    verdict_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        verdict_if.ready <= 1'b0;
        hold_left--;
      end else begin
        verdict_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_octet(logic [7:0] v, logic fin);
    stream_if.valid     <= 1'b1;
    stream_if.data_byte <= v;
    stream_if.last      <= fin;
    @(posedge clk);
    while (!stream_if.ready) @(posedge clk);
    while ($urandom_range(99) < gap_pct) begin
      stream_if.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_octet(stream_bytes[i], i == stream_bytes.size() - 1);
    stream_bytes.delete();
  endtask

  function automatic void add_octet(logic [7:0] v);
    stream_bytes.insert(stream_bytes.size(), v);
  endfunction

  function automatic logic [7:0] odd_octet();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'h7F;
      2: return 8'h80;
      3: return BYTE_FE;
      4: return BYTE_FF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_utf8();
    int chars;
    int n;
    logic [7:0] r;
    chars = $urandom_range(1, 4);
    repeat (chars) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : $urandom_range(0, 2);
      r = 8'($urandom);
      case (n)
        0: add_octet({1'b0, r[6:0]});
        1: add_octet({3'b110, r[4:0]});
        2: add_octet({4'b1110, r[3:0]});
        3: add_octet({5'b11110, r[2:0]});
        4: add_octet({6'b111110, r[1:0]});
        default: add_octet({7'b1111110, r[0]});
      endcase
      repeat (n) begin
        r = 8'($urandom);
        add_octet({2'b10, r[5:0]});
      end
    end
  endtask

  task automatic add_ansi();
    logic [7:0] r;
    repeat ($urandom_range(1, 4)) begin
      r = 8'($urandom);
      if ($urandom_range(0, 1) == 0) begin
        add_octet({1'b0, r[6:0]});
      end else begin
        add_octet({1'b1, r[6:0]});
        r = 8'($urandom);
        add_octet({1'b1, r[6:0]});
      end
    end
  endtask

  // A high byte followed by a low one breaks the ANSI rule, so the mark decides.
  task automatic add_ansi_breaker();
    logic [7:0] r;
    r = 8'($urandom);
    add_octet({1'b1, r[6:0]});
    r = 8'($urandom);
    add_octet({1'b0, r[6:0]});
  endtask

  task automatic add_utf16();
    bit le;
    le = $urandom_range(0, 1);
    add_octet(le ? BYTE_FF : BYTE_FE);
    add_octet(le ? BYTE_FE : BYTE_FF);
    if ($urandom_range(0, 3) != 0) add_ansi_breaker();
    repeat (2 * $urandom_range(0, 3)) add_octet(8'($urandom));
  endtask

  task automatic add_utf32();
    bit ff_first;
    ff_first = $urandom_range(0, 1);
    add_octet(BYTE_ZERO);
    add_octet(BYTE_ZERO);
    add_octet(ff_first ? BYTE_FF : BYTE_FE);
    add_octet(ff_first ? BYTE_FE : BYTE_FF);
    if ($urandom_range(0, 3) != 0) begin
      add_ansi_breaker();
      repeat (2) add_octet(8'($urandom));
    end
    repeat (4 * $urandom_range(0, 1)) add_octet(8'($urandom));
  endtask

  task automatic add_noise(int max_len);
    repeat ($urandom_range(1, max_len)) add_octet(odd_octet());
  endtask

  task automatic add_broken();
    int pick;
    add_utf8();
    case ($urandom_range(0, 2))
      0: if (stream_bytes.size() > 1) stream_bytes.pop_back();
      1: begin
        pick = $urandom_range(0, stream_bytes.size() - 1);
        stream_bytes[pick] = odd_octet();
      end
      default: add_octet({3'b110, 5'($urandom)});
    endcase
  endtask

  task automatic run_random(int octet_goal);
    int sent;
    sent = 0;
    while (sent < octet_goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_utf8();
        3:       add_ansi();
        4:       add_utf16();
        5:       add_utf32();
        6, 7:    add_broken();
        default: add_noise(8);
      endcase
      sent += stream_bytes.size();
      send_stream();
    end
  endtask

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    stream_if.valid     = 1'b0;
    stream_if.data_byte = 8'h00;
    stream_if.last      = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    stream_bytes = '{8'h41};
    send_stream();
    stream_bytes = '{8'hC3, 8'hA9};
    send_stream();
    stream_bytes = '{8'hFC, 8'h80, 8'hBF, 8'h80, 8'h80, 8'h80};
    send_stream();
    stream_bytes = '{8'h80, 8'h80};
    send_stream();
    stream_bytes = '{8'hFF, 8'hFE, 8'h41, 8'h80};
    send_stream();
    stream_bytes = '{8'hFE, 8'hFF, 8'h80, 8'h41};
    send_stream();
    stream_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFE, 8'h80, 8'h00, 8'h7F, 8'h00};
    send_stream();
    stream_bytes = '{8'hC3};
    send_stream();
    stream_bytes = '{8'hFF, 8'h41};
    send_stream();

    run_random(100);
    gap_pct = 64;
    run_random(100);
    gap_pct   = 0;
    stall_pct = 64;
    run_random(100);
    gap_pct   = 27;
    stall_pct = 27;
    run_random(100);

    // Short streams against a blocked receiver fill the output register and back up the input.
    gap_pct     = 0;
    stall_pct   = 0;
    pressure_on = 1'b1;
    repeat (30) begin
      add_noise(2);
      send_stream();
    end

    stream_if.valid <= 1'b0;
    stream_if.last  <= 1'b0;
    while (sb.verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
